>>> design/htw_pkg.sv
// ----------------------------------------------------------------------------
// Hashed timer wheel package
// Shared widths, codes, controller states and the command and status bundles
// that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package htw_pkg;

  localparam int unsigned NumBucketsDef       = 10;
  localparam int unsigned EntriesPerBucketDef = 8;

  localparam int unsigned TaskW  = 8;
  localparam int unsigned DelayW = 16;

  localparam logic FUNC_ADD  = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  typedef enum logic [1:0] {
    KIND_ADD_OK   = 2'd0,
    KIND_ADD_FULL = 2'd1,
    KIND_FIRED    = 2'd2,
    KIND_NONE     = 2'd3
  } kind_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_CORR,
    ST_BKT,
    ST_ADD,
    ST_TICK_START,
    ST_TICK_RD,
    ST_TICK_EV,
    ST_TICK_END
  } ctrl_state_e;

  typedef struct packed {
    logic load_in;
    logic corr_en;
    logic bkt_en;
    logic add_commit;
    logic tick_start;
    logic tick_read;
    logic tick_eval;
    logic tick_end;
  } cmd_t;

  typedef struct packed {
    logic is_tick;
    logic out_free;
    logic scan_more;
    logic eval_stall;
  } status_t;

endpackage

>>> design/htw_in_if.sv
// ----------------------------------------------------------------------------
// Hashed timer wheel input channel
// Valid/ready channel that carries one schedule or tick request.
// ----------------------------------------------------------------------------
interface htw_in_if;
  import htw_pkg::*;

  logic                valid;
  logic                ready;
  logic                func;
  logic [TaskW-1:0]    task_id;
  logic [DelayW-1:0]   delay;

  modport source (output valid, func, task_id, delay, input ready);
  modport sink   (input valid, func, task_id, delay, output ready);
endinterface

>>> design/htw_out_if.sv
// ----------------------------------------------------------------------------
// Hashed timer wheel output channel
// Valid/ready channel that carries one result of the wheel.
// ----------------------------------------------------------------------------
interface htw_out_if;
  import htw_pkg::*;

  logic             valid;
  logic             ready;
  kind_e            kind;
  logic [TaskW-1:0] fired_task;
  logic             last;

  modport source (output valid, kind, fired_task, last, input ready);
  modport sink   (input valid, kind, fired_task, last, output ready);
endinterface

>>> design/htw_ctrl.sv
// ----------------------------------------------------------------------------
// Hashed timer wheel controller
// Sequences the add path and the bucket scan of a tick through the datapath.
// ----------------------------------------------------------------------------
module htw_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  htw_pkg::status_t status_i,
  output htw_pkg::cmd_t    cmd_o
);
  import htw_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = ST_DECODE;
        end
      end
      ST_DECODE: begin
        state_d = status_i.is_tick ? ST_TICK_START : ST_CORR;
      end
      ST_CORR: begin
        cmd_o.corr_en = 1'b1;
        state_d       = ST_BKT;
      end
      ST_BKT: begin
        cmd_o.bkt_en = 1'b1;
        state_d      = ST_ADD;
      end
      ST_ADD: begin
        if (status_i.out_free) begin
          cmd_o.add_commit = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      ST_TICK_START: begin
        cmd_o.tick_start = 1'b1;
        state_d          = ST_TICK_RD;
      end
      ST_TICK_RD: begin
        if (status_i.scan_more) begin
          cmd_o.tick_read = 1'b1;
          state_d         = ST_TICK_EV;
        end else begin
          state_d = ST_TICK_END;
        end
      end
      ST_TICK_EV: begin
        // A second firing entry must wait until the held one can move out.
        if (!status_i.eval_stall) begin
          cmd_o.tick_eval = 1'b1;
          state_d         = ST_TICK_RD;
        end
      end
      ST_TICK_END: begin
        if (status_i.out_free) begin
          cmd_o.tick_end = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

>>> design/htw_dp.sv
// ----------------------------------------------------------------------------
// Hashed timer wheel datapath
// Bucket arithmetic, fill counters, entry memory, scan indexes and the
// output register.
// ----------------------------------------------------------------------------
module htw_dp #(
  parameter int unsigned BUCKET_COUNT       = htw_pkg::NumBucketsDef,
  parameter int unsigned ENTRIES_PER_BUCKET = htw_pkg::EntriesPerBucketDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        func_i,
  input  logic [htw_pkg::TaskW-1:0]   task_id_i,
  input  logic [htw_pkg::DelayW-1:0]  delay_i,
  input  htw_pkg::cmd_t               cmd_i,
  output htw_pkg::status_t            status_o,
  htw_out_if.source                   out_o
);
  import htw_pkg::*;

  localparam int unsigned BW     = $clog2(BUCKET_COUNT);
  localparam int unsigned IW     = (ENTRIES_PER_BUCKET > 1) ? $clog2(ENTRIES_PER_BUCKET) : 1;
  localparam int unsigned FW     = $clog2(ENTRIES_PER_BUCKET + 1);
  localparam int unsigned AW     = BW + IW;
  localparam int unsigned Depth  = BUCKET_COUNT << IW;
  localparam int unsigned RW     = $clog2((2 ** DelayW - 1) / BUCKET_COUNT + 1);
  localparam int unsigned EW     = TaskW + RW;
  localparam int unsigned RecipW = DelayW + 1;
  localparam logic [RecipW-1:0] Recip  = RecipW'((2 ** DelayW) / BUCKET_COUNT);
  localparam logic [FW-1:0]     FillMax = FW'(ENTRIES_PER_BUCKET);
  localparam logic [BW-1:0]     BktLast = BW'(BUCKET_COUNT - 1);

  // Captured request.
  logic              func_q;
  logic [TaskW-1:0]  task_q;
  logic [DelayW-1:0] delay_q;

  // Quotient and remainder by the bucket count.
  logic [DelayW+RecipW-1:0] recip_prod;
  logic [DelayW-1:0]        q_est_q;
  logic [DelayW:0]          nb_prod;
  logic [DelayW:0]          rem_raw;
  logic                     rem_ge;
  logic [DelayW:0]          rem_fix;
  logic [DelayW-1:0]        quot;
  logic [BW-1:0]            rem_q;
  logic [RW-1:0]            rounds_q;
  logic [BW:0]              bkt_sum;
  logic [BW-1:0]            bucket_q;

  // Wheel state.
  logic [BW-1:0] cur_q;
  logic [FW-1:0] fill_q [BUCKET_COUNT];
  logic [FW-1:0] fill_add;
  logic [FW-1:0] fill_cur;
  logic          add_full;
  logic          fill_we;
  logic [BW-1:0] fill_widx;
  logic [FW-1:0] fill_wdata;

  // Entry memory.
  logic [EW-1:0] entry_mem [Depth];
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [EW-1:0] mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [EW-1:0] rd_data_q;
  logic [RW-1:0] rd_rounds;
  logic [TaskW-1:0] rd_task;
  logic          rd_fire;

  // Scan state.
  logic [FW-1:0]    rd_idx_q;
  logic [FW-1:0]    wr_idx_q;
  logic             pend_valid_q;
  logic [TaskW-1:0] pend_task_q;

  // Output register.
  logic             out_valid_q;
  kind_e            out_kind_q;
  logic [TaskW-1:0] out_task_q;
  logic             out_last_q;
  logic             out_free;
  logic             push;
  kind_e            push_kind;
  logic [TaskW-1:0] push_task;
  logic             push_last;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      func_q  <= func_i;
      task_q  <= task_id_i;
      delay_q <= delay_i;
    end
  end

  // The reciprocal estimate is at most one below the true quotient.
  assign recip_prod = {{RecipW{1'b0}}, delay_q} * {{DelayW{1'b0}}, Recip};

  always_ff @(posedge clk_i) begin
    q_est_q <= recip_prod[2*DelayW-1:DelayW];
  end

  assign nb_prod = (DelayW + 1)'(q_est_q) * (DelayW + 1)'(BUCKET_COUNT);
  assign rem_raw = {1'b0, delay_q} - nb_prod;
  assign rem_ge  = (rem_raw >= (DelayW + 1)'(BUCKET_COUNT));
  assign rem_fix = rem_ge ? (rem_raw - (DelayW + 1)'(BUCKET_COUNT)) : rem_raw;
  assign quot    = q_est_q + DelayW'(rem_ge);
  assign bkt_sum = {1'b0, cur_q} + {1'b0, rem_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.corr_en) begin
      rem_q    <= rem_fix[BW-1:0];
      rounds_q <= quot[RW-1:0];
    end
    if (cmd_i.bkt_en) begin
      bucket_q <= (bkt_sum >= (BW + 1)'(BUCKET_COUNT))
                  ? BW'(bkt_sum - (BW + 1)'(BUCKET_COUNT)) : bkt_sum[BW-1:0];
    end
  end

  assign fill_add  = fill_q[bucket_q];
  assign fill_cur  = fill_q[cur_q];
  assign add_full  = (fill_add >= FillMax);
  assign mem_raddr = {cur_q, rd_idx_q[IW-1:0]};
  assign rd_rounds = rd_data_q[RW-1:0];
  assign rd_task   = rd_data_q[EW-1:RW];
  assign rd_fire   = (rd_rounds == '0);
  assign out_free  = !out_valid_q || out_o.ready;

  always_comb begin
    push       = 1'b0;
    push_kind  = KIND_NONE;
    push_task  = '0;
    push_last  = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = '0;
    mem_wdata  = '0;
    fill_we    = 1'b0;
    fill_widx  = '0;
    fill_wdata = '0;
    if (cmd_i.add_commit) begin
      push      = 1'b1;
      push_kind = add_full ? KIND_ADD_FULL : KIND_ADD_OK;
      push_task = task_q;
      push_last = 1'b1;
      if (!add_full) begin
        mem_we     = 1'b1;
        mem_waddr  = {bucket_q, fill_add[IW-1:0]};
        mem_wdata  = {task_q, rounds_q};
        fill_we    = 1'b1;
        fill_widx  = bucket_q;
        fill_wdata = fill_add + 1'b1;
      end
    end
    if (cmd_i.tick_eval) begin
      if (rd_fire) begin
        // The held firing is not the final one, since another follows.
        push      = pend_valid_q;
        push_kind = KIND_FIRED;
        push_task = pend_task_q;
      end else begin
        mem_we    = 1'b1;
        mem_waddr = {cur_q, wr_idx_q[IW-1:0]};
        mem_wdata = {rd_task, rd_rounds - 1'b1};
      end
    end
    if (cmd_i.tick_end) begin
      push       = 1'b1;
      push_kind  = pend_valid_q ? KIND_FIRED : KIND_NONE;
      push_task  = pend_valid_q ? pend_task_q : '0;
      push_last  = 1'b1;
      fill_we    = 1'b1;
      fill_widx  = cur_q;
      fill_wdata = wr_idx_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < BUCKET_COUNT; i++) begin
        fill_q[i] <= '0;
      end
    end else if (fill_we) begin
      fill_q[fill_widx] <= fill_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      entry_mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.tick_read) begin
      rd_data_q <= entry_mem[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q        <= '0;
      rd_idx_q     <= '0;
      wr_idx_q     <= '0;
      pend_valid_q <= 1'b0;
    end else begin
      if (cmd_i.tick_start) begin
        rd_idx_q     <= '0;
        wr_idx_q     <= '0;
        pend_valid_q <= 1'b0;
      end
      if (cmd_i.tick_read) begin
        rd_idx_q <= rd_idx_q + 1'b1;
      end
      if (cmd_i.tick_eval) begin
        if (rd_fire) begin
          pend_valid_q <= 1'b1;
        end else begin
          wr_idx_q <= wr_idx_q + 1'b1;
        end
      end
      if (cmd_i.tick_end) begin
        cur_q <= (cur_q == BktLast) ? '0 : cur_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.tick_eval && rd_fire) begin
      pend_task_q <= rd_task;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (push) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      out_kind_q <= push_kind;
      out_task_q <= push_task;
      out_last_q <= push_last;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.kind       = out_kind_q;
  assign out_o.fired_task = out_task_q;
  assign out_o.last       = out_last_q;

  assign status_o.is_tick    = (func_q == FUNC_TICK);
  assign status_o.out_free   = out_free;
  assign status_o.scan_more  = (rd_idx_q < fill_cur);
  assign status_o.eval_stall = rd_fire && pend_valid_q && !out_free;

  a_push_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> out_free)
    else $error("result loaded while the output register is occupied");

  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.corr_en |=> (rem_q < BW'(BUCKET_COUNT - 1)) || (rem_q == BktLast))
    else $error("remainder by the bucket count out of range");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_we |-> (fill_wdata <= FillMax))
    else $error("bucket fill count above capacity");

  a_compact_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_idx_q <= rd_idx_q)
    else $error("scan write-back index ahead of read index");

  a_wheel_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.tick_end |=>
      (cur_q == (($past(cur_q) == BktLast) ? '0 : $past(cur_q) + 1'b1)))
    else $error("wheel pointer did not advance by one bucket");

endmodule

>>> design/hashed_timer_wheel.sv
// Add requests: one result, registered after the decode, correction, bucket and add states;
// the next request is taken only once the add has committed. Ticks: the F entries of the
// current bucket (at most 8 for a default bucket) are each read from memory and evaluated,
// the final result follows the scan, and only then is the next request taken. Output stalls delay both.
// Reset (asynchronous, active low) clears the wheel pointer, all fill counts and control;
// the entry memory is not cleared, and the wheel accepts requests right after reset.
// ----------------------------------------------------------------------------
// Hashed timer wheel
// Timer wheel that files tasks into buckets by delay and fires them on ticks.
// ----------------------------------------------------------------------------
module hashed_timer_wheel #(
  parameter int unsigned BUCKET_COUNT       = htw_pkg::NumBucketsDef,
  parameter int unsigned ENTRIES_PER_BUCKET = htw_pkg::EntriesPerBucketDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  htw_in_if.sink    in_i,
  htw_out_if.source out_o
);
  import htw_pkg::*;

  cmd_t    cmd;
  status_t status;

  htw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  htw_dp #(
    .BUCKET_COUNT       (BUCKET_COUNT),
    .ENTRIES_PER_BUCKET (ENTRIES_PER_BUCKET)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .func_i    (in_i.func),
    .task_id_i (in_i.task_id),
    .delay_i   (in_i.delay),
    .cmd_i     (cmd),
    .status_o  (status),
    .out_o     (out_o)
  );

endmodule
